/* rtl/hwfc_pkg.sv */
package hwfc_pkg;

  // Field widths fixed by the item formats.
  localparam int unsigned POS_W    = 8;
  localparam int unsigned HEIGHT_W = 16;
  localparam int unsigned DIM_W    = 9;
  localparam int unsigned RADIUS_W = 4;
  // A window coordinate carries one bit above a position, since a window may
  // reach past column or row 255 on a map wider than that.
  localparam int unsigned IDX_W    = POS_W + 1 + DIM_W;

  // Depth of the request queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Request opcodes.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_MAP_WIDTH  = 2'd0;
  localparam logic [1:0] REG_MAP_HEIGHT = 2'd1;
  localparam logic [1:0] REG_RADIUS     = 2'd2;
  localparam logic [1:0] REG_THRESHOLD  = 2'd3;

  typedef struct packed {
    logic                op;
    logic [POS_W-1:0]    pos_x;
    logic [POS_W-1:0]    pos_y;
    logic [HEIGHT_W-1:0] height_value;
    logic                already_hidden;
  } in_item_t;

  typedef struct packed {
    logic                hide;
    logic [HEIGHT_W-1:0] height_range;
    logic                out_of_map;
  } out_item_t;

  // Configuration after saturation to the build limits.
  typedef struct packed {
    logic [DIM_W-1:0]    map_width;
    logic [DIM_W-1:0]    map_height;
    logic [RADIUS_W-1:0] window_radius;
    logic [HEIGHT_W-1:0] flat_threshold;
  } cfg_t;

  // What the back end has to do with a request.
  typedef enum logic [2:0] {
    CLS_WRITE_IN,
    CLS_WRITE_OUT,
    CLS_QUERY_OUT,
    CLS_QUERY_HIDDEN,
    CLS_QUERY_WALK
  } cls_t;

  typedef struct packed {
    cls_t                cls;
    logic [POS_W-1:0]    pos_x;
    logic [POS_W-1:0]    pos_y;
    logic [HEIGHT_W-1:0] height_value;
  } entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_WALK,
    BS_DRAIN,
    BS_FINISH
  } bstate_t;

endpackage

/* rtl/hwfc_ram.sv */
module hwfc_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 65536,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* rtl/hwfc_front.sv */
module hwfc_front (
  input  hwfc_pkg::cfg_t                          cfg,
  input  logic                                    start,
  input  hwfc_pkg::in_item_t                      in_item,
  input  hwfc_pkg::q_status_t                     q_status,
  output logic                                    busy,
  output logic                                    push,
  output hwfc_pkg::entry_t                        push_data
);

  logic in_map;

  assign in_map = ({1'b0, in_item.pos_x} < cfg.map_width) &&
                  ({1'b0, in_item.pos_y} < cfg.map_height);

  assign busy = q_status.full;
  assign push = start && !q_status.full;

  always_comb begin
    push_data.pos_x        = in_item.pos_x;
    push_data.pos_y        = in_item.pos_y;
    push_data.height_value = in_item.height_value;
    if (in_item.op == hwfc_pkg::OP_WRITE) begin
      push_data.cls = in_map ? hwfc_pkg::CLS_WRITE_IN : hwfc_pkg::CLS_WRITE_OUT;
    end else if (!in_map) begin
      push_data.cls = hwfc_pkg::CLS_QUERY_OUT;
    end else if (in_item.already_hidden) begin
      push_data.cls = hwfc_pkg::CLS_QUERY_HIDDEN;
    end else begin
      push_data.cls = hwfc_pkg::CLS_QUERY_WALK;
    end
  end

endmodule

/* rtl/hwfc_queue.sv */
module hwfc_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  hwfc_pkg::entry_t    push_data,
  input  logic                pop,
  output hwfc_pkg::entry_t    pop_data,
  output hwfc_pkg::q_status_t status
);

  localparam int unsigned PTR_W = (hwfc_pkg::QUEUE_DEPTH > 1) ?
                                  $clog2(hwfc_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(hwfc_pkg::QUEUE_DEPTH + 1);

  hwfc_pkg::entry_t slot_r [hwfc_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
    return (32'(p) == hwfc_pkg::QUEUE_DEPTH - 1) ? '0 : p + 1'b1;
  endfunction

  assign status.empty = (count_r == '0);
  assign status.full  = (32'(count_r) == hwfc_pkg::QUEUE_DEPTH);
  assign pop_data     = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    status.full && !pop |-> !push)
    else $error("request queue pushed while full");

endmodule

/* rtl/hwfc_back.sv */
module hwfc_back #(
  parameter int unsigned DEPTH = 65536
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  hwfc_pkg::cfg_t       cfg,
  input  hwfc_pkg::entry_t     head,
  input  hwfc_pkg::q_status_t  q_status,
  output logic                 pop,
  output logic                 out_valid,
  output hwfc_pkg::out_item_t  out_result
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = hwfc_pkg::POS_W + 1;
  localparam int unsigned IW = hwfc_pkg::IDX_W;
  localparam int unsigned HW = hwfc_pkg::HEIGHT_W;

  hwfc_pkg::bstate_t state_r, state_nxt;

  logic [CW-1:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic [CW-1:0] x_lo_r, x_lo_nxt, x_hi_r, x_hi_nxt, y_hi_r, y_hi_nxt;
  logic          rd_pend_r, rd_pend_nxt;
  logic          first_r, first_nxt;
  logic [HW-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic          out_valid_r, out_valid_nxt;
  hwfc_pkg::out_item_t out_r, out_nxt;

  // Window bounds of the request at the queue head, clipped to the map.
  logic [CW-1:0] px, py, rad;
  logic [CW-1:0] hx_lo, hx_hi, hy_lo, hy_hi;
  logic [CW-1:0] hx_top, hy_top;
  logic [CW-1:0] w_last, h_last;

  logic [CW-1:0] mul_y, mul_x;
  logic [IW-1:0] lin_idx;
  logic          ram_we;
  logic [HW-1:0] ram_rdata;
  logic [HW-1:0] range_val;

  always_comb begin
    px     = {1'b0, head.pos_x};
    py     = {1'b0, head.pos_y};
    rad    = CW'(cfg.window_radius);
    w_last = CW'(cfg.map_width) - 1'b1;
    h_last = CW'(cfg.map_height) - 1'b1;
    hx_top = px + rad;
    hy_top = py + rad;
    hx_lo  = (px >= rad) ? px - rad : '0;
    hy_lo  = (py >= rad) ? py - rad : '0;
    hx_hi  = (hx_top > w_last) ? w_last : hx_top;
    hy_hi  = (hy_top > h_last) ? h_last : hy_top;
  end

  // One shared multiplier forms the row-major index for writes and walk reads.
  assign mul_y   = (state_r == hwfc_pkg::BS_IDLE) ? py : cy_r;
  assign mul_x   = (state_r == hwfc_pkg::BS_IDLE) ? px : cx_r;
  assign lin_idx = IW'(mul_y) * IW'(cfg.map_width) + IW'(mul_x);

  hwfc_ram #(
    .WIDTH (HW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (AW'(lin_idx)),
    .wdata (head.height_value),
    .rdata (ram_rdata)
  );

  assign range_val = hi_r - lo_r;

  always_comb begin
    state_nxt     = state_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    x_lo_nxt      = x_lo_r;
    x_hi_nxt      = x_hi_r;
    y_hi_nxt      = y_hi_r;
    rd_pend_nxt   = 1'b0;
    first_nxt     = first_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    pop           = 1'b0;
    ram_we        = 1'b0;
    unique case (state_r)
      hwfc_pkg::BS_IDLE: begin
        if (!q_status.empty) begin
          pop     = 1'b1;
          out_nxt = '0;
          case (head.cls) inside
            hwfc_pkg::CLS_WRITE_IN: begin
              ram_we        = 1'b1;
              out_valid_nxt = 1'b1;
            end
            hwfc_pkg::CLS_WRITE_OUT, hwfc_pkg::CLS_QUERY_OUT: begin
              out_nxt.out_of_map = 1'b1;
              out_valid_nxt      = 1'b1;
            end
            hwfc_pkg::CLS_QUERY_HIDDEN: begin
              out_nxt.hide  = 1'b1;
              out_valid_nxt = 1'b1;
            end
            default: begin
              cx_nxt    = hx_lo;
              cy_nxt    = hy_lo;
              x_lo_nxt  = hx_lo;
              x_hi_nxt  = hx_hi;
              y_hi_nxt  = hy_hi;
              first_nxt = 1'b1;
              state_nxt = hwfc_pkg::BS_WALK;
            end
          endcase
        end
      end
      hwfc_pkg::BS_WALK: begin
        rd_pend_nxt = 1'b1;
        if (cx_r == x_hi_r) begin
          cx_nxt = x_lo_r;
          if (cy_r == y_hi_r) begin
            state_nxt = hwfc_pkg::BS_DRAIN;
          end else begin
            cy_nxt = cy_r + 1'b1;
          end
        end else begin
          cx_nxt = cx_r + 1'b1;
        end
      end
      hwfc_pkg::BS_DRAIN: begin
        state_nxt = hwfc_pkg::BS_FINISH;
      end
      hwfc_pkg::BS_FINISH: begin
        out_nxt.hide         = (range_val > cfg.flat_threshold);
        out_nxt.height_range = range_val;
        out_nxt.out_of_map   = 1'b0;
        out_valid_nxt        = 1'b1;
        state_nxt            = hwfc_pkg::BS_IDLE;
      end
      default: begin
        state_nxt = hwfc_pkg::BS_IDLE;
      end
    endcase
  end

  // Running minimum and maximum over the samples returned by the store.
  always_comb begin
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    if (rd_pend_r) begin
      if (first_r || ram_rdata < lo_r) begin
        lo_nxt = ram_rdata;
      end
      if (first_r || ram_rdata > hi_r) begin
        hi_nxt = ram_rdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hwfc_pkg::BS_IDLE;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cx_r    <= cx_nxt;
    cy_r    <= cy_nxt;
    x_lo_r  <= x_lo_nxt;
    x_hi_r  <= x_hi_nxt;
    y_hi_r  <= y_hi_nxt;
    first_r <= rd_pend_r ? 1'b0 : first_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    out_r   <= out_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_r;

  a_read_from_walk: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> $past(state_r == hwfc_pkg::BS_WALK))
    else $error("store read data without a walk read");

  a_result_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == hwfc_pkg::BS_IDLE)
    else $error("result strobe outside idle");

  a_out_of_map_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.out_of_map |-> !out_r.hide && out_r.height_range == '0)
    else $error("out-of-map result carries hide or range");

  a_no_pop_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != hwfc_pkg::BS_IDLE |-> !pop)
    else $error("queue popped while a query is in progress");

endmodule

/* rtl/height_window_flatness_check.sv */
// Height-window flatness check. The block keeps a height map of up to
// MAX_COLUMNS by MAX_ROWS 16-bit samples in a single-port memory, stored row
// major with the stride of map_width. A write request stores one sample when
// its cell lies inside the map and is dropped otherwise; a query request walks
// the square window of radius window_radius around its cell, clipped to the
// map, and reports the range max minus min and hide when that range exceeds
// flat_threshold. A query of an already hidden cell reports hide at once, and
// any request outside the map reports out_of_map. Every request gives exactly
// one result, in request order. Requests are taken whenever busy is low, which
// happens while the two-entry request queue has room, so a new request can be
// accepted while the back end still works. The back end takes a write or a
// query that needs no walk while idle and registers its result strobe for the
// cycle after. A walking query reads one stored height per cycle in WALK, row
// by row, then passes DRAIN and FINISH and takes no new request before its
// result. The result is shown on out_result for a single cycle marked by
// out_valid; the receiver cannot stall it, so it must take every strobe.
// The store is not cleared after reset: a window that touches a cell never
// written gives an undefined range. Configuration is written through the APB
// port while no request is in flight, a rule for the user that the block does
// not enforce; map sizes and radius above the build limits saturate to them.
module height_window_flatness_check #(
  parameter int unsigned MAX_COLUMNS = 256,
  parameter int unsigned MAX_ROWS    = 256,
  parameter int unsigned MAX_RADIUS  = 15
) (
  input  logic                clk,
  input  logic                rst_n,
  // Request channel.
  input  logic                start,
  output logic                busy,
  input  hwfc_pkg::in_item_t  in_item,
  // Result channel.
  output logic                out_valid,
  output hwfc_pkg::out_item_t out_result,
  // Configuration port.
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int unsigned DEPTH = MAX_COLUMNS * MAX_ROWS;

  // Configuration registers as written; saturation is applied on the way out.
  logic [hwfc_pkg::DIM_W-1:0]    map_width_r;
  logic [hwfc_pkg::DIM_W-1:0]    map_height_r;
  logic [hwfc_pkg::RADIUS_W-1:0] radius_r;
  logic [hwfc_pkg::HEIGHT_W-1:0] threshold_r;

  logic             cfg_write;
  hwfc_pkg::cfg_t   cfg;

  hwfc_pkg::entry_t    push_data, head;
  hwfc_pkg::q_status_t q_status;
  logic                push, pop;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_width_r  <= hwfc_pkg::DIM_W'(256);
      map_height_r <= hwfc_pkg::DIM_W'(256);
      radius_r     <= hwfc_pkg::RADIUS_W'(1);
      threshold_r  <= '0;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        hwfc_pkg::REG_MAP_WIDTH:  map_width_r  <= pwdata[hwfc_pkg::DIM_W-1:0];
        hwfc_pkg::REG_MAP_HEIGHT: map_height_r <= pwdata[hwfc_pkg::DIM_W-1:0];
        hwfc_pkg::REG_RADIUS:     radius_r     <= pwdata[hwfc_pkg::RADIUS_W-1:0];
        hwfc_pkg::REG_THRESHOLD:  threshold_r  <= pwdata[hwfc_pkg::HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      hwfc_pkg::REG_MAP_WIDTH:  prdata = 32'(map_width_r);
      hwfc_pkg::REG_MAP_HEIGHT: prdata = 32'(map_height_r);
      hwfc_pkg::REG_RADIUS:     prdata = 32'(radius_r);
      hwfc_pkg::REG_THRESHOLD:  prdata = 32'(threshold_r);
      default:                  prdata = '0;
    endcase
  end

  // Effective configuration, clipped to what the memory and window can hold.
  always_comb begin
    cfg.map_width      = (32'(map_width_r) > MAX_COLUMNS) ?
                         hwfc_pkg::DIM_W'(MAX_COLUMNS) : map_width_r;
    cfg.map_height     = (32'(map_height_r) > MAX_ROWS) ?
                         hwfc_pkg::DIM_W'(MAX_ROWS) : map_height_r;
    cfg.window_radius  = (32'(radius_r) > MAX_RADIUS) ?
                         hwfc_pkg::RADIUS_W'(MAX_RADIUS) : radius_r;
    cfg.flat_threshold = threshold_r;
  end

  // The front end classifies each request against the map before queueing.
  hwfc_front u_front (
    .cfg       (cfg),
    .start     (start),
    .in_item   (in_item),
    .q_status  (q_status),
    .busy      (busy),
    .push      (push),
    .push_data (push_data)
  );

  hwfc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (head),
    .status    (q_status)
  );

  // The back end owns the height store and produces every result.
  hwfc_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .head       (head),
    .q_status   (q_status),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

endmodule
